/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while dis is high.
`define SFB_ASSERT_NOW(label, clk_s, dis, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while dis is high.
`define SFB_ASSERT_NEXT(label, clk_s, dis, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sfb_pkg.sv */
// Types and constants shared by the feather blending block.
package sfb_pkg;

  localparam int COL_W     = 12;
  localparam int END_W     = 13;
  localparam int CH_W      = 8;
  localparam int W_W       = 17;
  localparam int DIV_STEPS = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [W_W-1:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd2;

  localparam logic [COL_W-1:0] START_RESET = 12'd0;
  localparam logic [END_W-1:0] END_RESET   = 13'd640;
  localparam logic [CH_W-1:0]  DARK_RESET  = 8'd50;

  typedef struct packed {
    logic [COL_W-1:0] overlap_start;
    logic [END_W-1:0] overlap_end;
    logic [CH_W-1:0]  dark_threshold;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  // How the reference weight of a pixel is found
  typedef enum logic [1:0] {
    MODE_REF,
    MODE_WARP,
    MODE_BLEND
  } mode_t;

  typedef struct packed {
    mode_t mode;
    rgb_t  ref_px;
    rgb_t  warp_px;
  } item_t;

endpackage

/* rtl/seam_feather_blend.sv */
// Top level of the seam feather blending block.
//
// Input channel: in_valid / in_stall carry a column index with a reference
// and a warped RGB pixel. A transfer happens at a rising edge with in_valid
// high and in_stall low.
// Output channel: out_valid / out_stall carry the stitched RGB pixel, one per
// input pixel, in input order.
// Configuration: cfg_valid / cfg_ready write register cfg_index with
// cfg_data (0 overlap start, 1 overlap end, clamped to MAX_COLUMNS,
// 2 dark threshold). cfg_ready is always high; write only while idle.
// Throughput: one pixel per clock while out_stall is low. A pixel passes
// the entry register, the 17-stage restoring divider that forms the Q1.16
// reference weight, the colour lane registers and the output register.
// Reset (rst, synchronous) empties the pipeline and loads the overlap as
// 0..640 with a dark threshold of 50.
// A stalled output holds its pixel; empty stages still fill behind it, and
// in_stall rises only once every stage up to the input is occupied.
module seam_feather_blend import sfb_pkg::*; #(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [END_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COL_W-1:0]     column,
  input  logic [CH_W-1:0]      ref_blue,
  input  logic [CH_W-1:0]      ref_green,
  input  logic [CH_W-1:0]      ref_red,
  input  logic [CH_W-1:0]      warped_blue,
  input  logic [CH_W-1:0]      warped_green,
  input  logic [CH_W-1:0]      warped_red,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CH_W-1:0]      out_blue,
  output logic [CH_W-1:0]      out_green,
  output logic [CH_W-1:0]      out_red
);

  localparam logic [16:0] MAX_END = 17'(MAX_COLUMNS);

  cfg_t             cfg;
  logic [END_W-1:0] end_wr;
  logic             in_ready;
  logic             wp_valid;
  logic [W_W-1:0]   wp_weight;
  rgb_t             wp_ref;
  rgb_t             wp_warp;
  rgb_t             lane_px;
  logic             lane_valid;
  logic             lane_ready;
  logic             lane_en;
  logic             out_ready;

  assign cfg_ready = 1'b1;
  assign end_wr    = ({4'b0, cfg_data} > MAX_END) ? MAX_END[END_W-1:0] : cfg_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overlap_start  <= START_RESET;
      cfg.overlap_end    <= END_RESET;
      cfg.dark_threshold <= DARK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OVERLAP_START:  cfg.overlap_start  <= cfg_data[COL_W-1:0];
        REG_OVERLAP_END:    cfg.overlap_end    <= end_wr;
        REG_DARK_THRESHOLD: cfg.dark_threshold <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  sfb_weight_pipe u_weight (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .column    (column),
    .ref_px    ('{blue: ref_blue, green: ref_green, red: ref_red}),
    .warp_px   ('{blue: warped_blue, green: warped_green, red: warped_red}),
    .out_valid (wp_valid),
    .out_ready (lane_ready),
    .weight    (wp_weight),
    .out_ref   (wp_ref),
    .out_warp  (wp_warp)
  );

  // Colour lanes share one valid bit
  assign out_ready  = !out_valid || !out_stall;
  assign lane_ready = !lane_valid || out_ready;
  assign lane_en    = lane_ready && wp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (lane_ready) begin
      lane_valid <= wp_valid;
    end
  end

  sfb_mix_lane u_lane_blue (
    .clk     (clk),
    .en      (lane_en),
    .weight  (wp_weight),
    .ref_ch  (wp_ref.blue),
    .warp_ch (wp_warp.blue),
    .mixed   (lane_px.blue)
  );

  sfb_mix_lane u_lane_green (
    .clk     (clk),
    .en      (lane_en),
    .weight  (wp_weight),
    .ref_ch  (wp_ref.green),
    .warp_ch (wp_warp.green),
    .mixed   (lane_px.green)
  );

  sfb_mix_lane u_lane_red (
    .clk     (clk),
    .en      (lane_en),
    .weight  (wp_weight),
    .ref_ch  (wp_ref.red),
    .warp_ch (wp_warp.red),
    .mixed   (lane_px.red)
  );

  // Merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && lane_valid) begin
      out_blue  <= lane_px.blue;
      out_green <= lane_px.green;
      out_red   <= lane_px.red;
    end
  end

endmodule

/* rtl/sfb_weight_pipe.sv */
// Pixel classification and pipelined restoring divider for the reference weight.
module sfb_weight_pipe import sfb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [COL_W-1:0] column,
  input  rgb_t             ref_px,
  input  rgb_t             warp_px,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [W_W-1:0]   weight,
  output rgb_t             out_ref,
  output rgb_t             out_warp
);

  localparam int NST = DIV_STEPS + 1;

  logic             valid [NST];
  logic [NST-1:0]   rdy;
  item_t            item  [NST];
  logic [END_W-1:0] rem   [NST];
  logic [W_W-1:0]   quo   [NST];

  logic [END_W-1:0] span;
  logic [END_W-1:0] left_in;
  logic             dark;
  mode_t            mode_in;

  assign span    = cfg.overlap_end - {1'b0, cfg.overlap_start};
  assign left_in = cfg.overlap_end - {1'b0, column};
  assign dark    = (warp_px.blue  < cfg.dark_threshold) &&
                   (warp_px.green < cfg.dark_threshold) &&
                   (warp_px.red   < cfg.dark_threshold);

  // Classify the incoming pixel against the overlap
  always_comb begin
    if (column < cfg.overlap_start) begin
      mode_in = MODE_REF;
    end else if ({1'b0, column} >= cfg.overlap_end) begin
      mode_in = MODE_WARP;
    end else if (dark) begin
      mode_in = MODE_REF;
    end else begin
      mode_in = MODE_BLEND;
    end
  end

  // A stage moves on when it is empty or the next one moves on
  assign rdy[NST-1] = !valid[NST-1] || out_ready;
  genvar k;
  generate
    for (k = 0; k < NST - 1; k++) begin : g_rdy
      assign rdy[k] = !valid[k] || rdy[k+1];
    end
  endgenerate

  assign in_ready = rdy[0];

  // Entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (rdy[0]) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      item[0] <= '{mode: mode_in, ref_px: ref_px, warp_px: warp_px};
      rem[0]  <= left_in;
      quo[0]  <= '0;
    end
  end

  // One quotient bit per stage; the first stage yields the integer bit
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [END_W:0] shifted;
      logic [END_W:0] diff;
      logic           take;

      if (k == 0) begin : g_first
        assign shifted = {1'b0, rem[k]};
      end else begin : g_rest
        assign shifted = {rem[k], 1'b0};
      end

      assign diff = shifted - {1'b0, span};
      assign take = shifted >= {1'b0, span};

      always_ff @(posedge clk) begin
        if (rst) begin
          valid[k+1] <= 1'b0;
        end else if (rdy[k+1]) begin
          valid[k+1] <= valid[k];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k+1] && valid[k]) begin
          item[k+1] <= item[k];
          rem[k+1]  <= take ? diff[END_W-1:0] : shifted[END_W-1:0];
          quo[k+1]  <= {quo[k][W_W-2:0], take};
        end
      end
    end
  endgenerate

  // Pick the weight for the finished pixel
  always_comb begin
    case (item[NST-1].mode)
      MODE_REF:   weight = ONE_Q16;
      MODE_WARP:  weight = '0;
      MODE_BLEND: weight = quo[NST-1];
      default:    weight = '0;
    endcase
  end

  assign out_valid = valid[NST-1];
  assign out_ref   = item[NST-1].ref_px;
  assign out_warp  = item[NST-1].warp_px;

endmodule

/* rtl/sfb_mix_lane.sv */
// One colour lane: weighted sum of reference and warped channel, registered.
module sfb_mix_lane import sfb_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [W_W-1:0]  weight,
  input  logic [CH_W-1:0] ref_ch,
  input  logic [CH_W-1:0] warp_ch,
  output logic [CH_W-1:0] mixed
);

  localparam int PROD_W = W_W + CH_W;

  logic [W_W-1:0]    weight_warp;
  logic [PROD_W-1:0] prod_ref;
  logic [PROD_W-1:0] prod_warp;
  logic [PROD_W-1:0] acc;

  assign weight_warp = ONE_Q16 - weight;
  assign prod_ref    = {{W_W{1'b0}}, ref_ch}  * {{CH_W{1'b0}}, weight};
  assign prod_warp   = {{W_W{1'b0}}, warp_ch} * {{CH_W{1'b0}}, weight_warp};
  assign acc         = prod_ref + prod_warp;

  // Drop the 16 fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      mixed <= acc[16 +: CH_W];
    end
  end

endmodule

/* rtl/sfb_checker.sv */
// Port-level checks for the seam feather blending block, bound to the top level.
`include "assert_macros.svh"

module sfb_checker import sfb_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [CH_W-1:0] out_blue,
  input logic [CH_W-1:0] out_green,
  input logic [CH_W-1:0] out_red
);

  // Hold a stalled result
  `SFB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(out_blue) && $stable(out_green) && $stable(out_red),
    "stalled output pixel changed")

  // Drop out_valid only after a transfer
  `SFB_ASSERT_NOW(a_out_drop, clk, rst, $fell(out_valid), $past(!out_stall),
    "output pixel dropped without transfer")

  // Backpressure at the input only comes from a stalled output
  `SFB_ASSERT_NOW(a_no_idle_stall, clk, rst, !out_stall, !in_stall,
    "input stalled while output drains freely")

  // Reset empties the pipeline
  `SFB_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid && !in_stall,
    "pipeline not empty after reset")

endmodule

bind seam_feather_blend sfb_checker u_sfb_checker (.*);

/* sim/seam_feather_blend_tb.sv */
// Self-checking testbench for the seam feather blending block.
`timescale 1ns / 100ps

module seam_feather_blend_tb;
  import sfb_pkg::*;

  localparam int MAX_COLS   = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 25;

  // One pixel offered to the block: column plus reference and warped colour
  typedef struct packed {
    logic [COL_W-1:0] column;
    rgb_t             ref_px;
    rgb_t             warp_px;
  } px_in_t;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_OVERLAP_START;
  logic [END_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [COL_W-1:0]     column       = '0;
  logic [CH_W-1:0]      ref_blue     = '0;
  logic [CH_W-1:0]      ref_green    = '0;
  logic [CH_W-1:0]      ref_red      = '0;
  logic [CH_W-1:0]      warped_blue  = '0;
  logic [CH_W-1:0]      warped_green = '0;
  logic [CH_W-1:0]      warped_red   = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [CH_W-1:0]      out_blue;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_red;

  // Shadow of the block's registers, as they stand after reset
  cfg_t   blend_cfg = '{overlap_start: START_RESET, overlap_end: END_RESET,
                        dark_threshold: DARK_RESET};
  px_in_t pixel_q[$];
  rgb_t   stitched_q[$];
  px_in_t drv_px;
  rgb_t   want_px;
  int     pixels_queued  = 0;
  int     pixels_done    = 0;
  int     err_count      = 0;
  int     cycle_count    = 0;
  int     send_idle_pct  = 0;
  int     recv_idle_pct  = 0;

  seam_feather_blend #(.MAX_COLUMNS(MAX_COLS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .column       (column),
    .ref_blue     (ref_blue),
    .ref_green    (ref_green),
    .ref_red      (ref_red),
    .warped_blue  (warped_blue),
    .warped_green (warped_green),
    .warped_red   (warped_red),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_blue     (out_blue),
    .out_green    (out_green),
    .out_red      (out_red)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mix one channel with a Q1.16 reference weight, truncating
  function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] r,
                                                   input logic [CH_W-1:0] w,
                                                   input logic [W_W-1:0] w_ref);
    logic [31:0] acc;
    acc = r * w_ref + w * (ONE_Q16 - w_ref);
    return acc[23:16];
  endfunction

  // Stitched pixel for one input pixel under the current register settings
  function automatic rgb_t blend_pixel(input px_in_t px);
    mode_t          mode;
    logic [W_W-1:0] w_ref;
    logic [31:0]    span;
    logic [31:0]    left;
    logic [31:0]    quot;
    rgb_t           res;
    if (px.column < blend_cfg.overlap_start) begin
      mode = MODE_REF;
    end else if ({1'b0, px.column} >= blend_cfg.overlap_end) begin
      mode = MODE_WARP;
    end else if (px.warp_px.blue < blend_cfg.dark_threshold &&
                 px.warp_px.green < blend_cfg.dark_threshold &&
                 px.warp_px.red < blend_cfg.dark_threshold) begin
      // empty warped pixel keeps the reference
      mode = MODE_REF;
    end else begin
      mode = MODE_BLEND;
    end
    case (mode)
      MODE_REF: w_ref = ONE_Q16;
      MODE_WARP: w_ref = '0;
      default: begin
        span = blend_cfg.overlap_end - blend_cfg.overlap_start;
        left = blend_cfg.overlap_end - px.column;
        quot = (left << 16) / span;
        w_ref = (quot > ONE_Q16) ? ONE_Q16 : quot[W_W-1:0];
      end
    endcase
    res.blue  = mix_channel(px.ref_px.blue, px.warp_px.blue, w_ref);
    res.green = mix_channel(px.ref_px.green, px.warp_px.green, w_ref);
    res.red   = mix_channel(px.ref_px.red, px.warp_px.red, w_ref);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Write one register and mirror it in the shadow copy
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [END_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OVERLAP_START: blend_cfg.overlap_start = data[COL_W-1:0];
      REG_OVERLAP_END: blend_cfg.overlap_end = (data > MAX_COLS) ? END_W'(MAX_COLS) : data;
      REG_DARK_THRESHOLD: blend_cfg.dark_threshold = data[CH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [END_W-1:0] start_v,
                              input logic [END_W-1:0] end_v,
                              input logic [END_W-1:0] dark_v);
    cfg_write(REG_OVERLAP_START, start_v);
    cfg_write(REG_OVERLAP_END, end_v);
    cfg_write(REG_DARK_THRESHOLD, dark_v);
  endtask

  task automatic push_pixel(input logic [COL_W-1:0] col,
                            input logic [CH_W-1:0] rb, input logic [CH_W-1:0] rg,
                            input logic [CH_W-1:0] rr, input logic [CH_W-1:0] wb,
                            input logic [CH_W-1:0] wg, input logic [CH_W-1:0] wr);
    px_in_t px;
    px.column  = col;
    px.ref_px  = '{blue: rb, green: rg, red: rr};
    px.warp_px = '{blue: wb, green: wg, red: wr};
    pixel_q = {pixel_q, px};
    pixels_queued++;
  endtask

  // Warped channel: often dark or near the threshold, otherwise anything
  function automatic logic [CH_W-1:0] pick_warp(input int sel);
    int thr;
    thr = blend_cfg.dark_threshold;
    if (sel < 30 && thr > 0) return CH_W'($urandom_range(0, thr - 1));
    if (sel < 45) return CH_W'(thr + $urandom_range(0, 2) - 1);
    return CH_W'($urandom_range(0, 255));
  endfunction

  // Queue random pixels, biased towards the overlap and its edges
  task automatic add_random(input int n);
    int lo;
    int hi;
    int r;
    int sel;
    logic [COL_W-1:0] col;
    lo = blend_cfg.overlap_start;
    hi = blend_cfg.overlap_end;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 5 && hi > lo) begin
        col = COL_W'($urandom_range(lo, hi - 1));
      end else if (r < 7) begin
        case ($urandom_range(0, 3))
          0: col = COL_W'(lo - 1);
          1: col = COL_W'(lo);
          2: col = COL_W'(hi - 1);
          default: col = COL_W'(hi);
        endcase
      end else begin
        col = COL_W'($urandom_range(0, 4095));
      end
      // one choice for all three channels keeps dark pixels frequent
      sel = $urandom_range(0, 99);
      push_pixel(col, CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                 CH_W'($urandom_range(0, 255)), pick_warp(sel), pick_warp(sel),
                 pick_warp(sel));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pixels_done != pixels_queued);
  endtask

  // Driver: present queued pixels, hold while stalled, idle at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        stitched_q = {stitched_q, blend_pixel(drv_px)};
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_px = pixel_q.pop_front();
          in_valid     <= 1'b1;
          column       <= drv_px.column;
          ref_blue     <= drv_px.ref_px.blue;
          ref_green    <= drv_px.ref_px.green;
          ref_red      <= drv_px.ref_px.red;
          warped_blue  <= drv_px.warp_px.blue;
          warped_green <= drv_px.warp_px.green;
          warped_red   <= drv_px.warp_px.red;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stitched_q.size() == 0) begin
          report_mismatch("output pixel with none pending");
        end else begin
          want_px = stitched_q.pop_front();
          pixels_done++;
          if (out_blue !== want_px.blue)
            report_mismatch($sformatf("blue expected %0d got %0d", want_px.blue, out_blue));
          if (out_green !== want_px.green)
            report_mismatch($sformatf("green expected %0d got %0d", want_px.green,
                                      out_green));
          if (out_red !== want_px.red)
            report_mismatch($sformatf("red expected %0d got %0d", want_px.red, out_red));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL seam_feather_blend");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Sender idles a little, receiver a lot
    send_idle_pct = 12;
    recv_idle_pct = 70;

    // Directed pixels under the reset overlap of 0..640, threshold 50
    push_pixel(12'd0,    8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00);
    push_pixel(12'd0,    8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff);
    push_pixel(12'd639,  8'hff, 8'hff, 8'hff, 8'h80, 8'h80, 8'h80);
    push_pixel(12'd639,  8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff);
    push_pixel(12'd640,  8'hff, 8'hff, 8'hff, 8'h12, 8'h34, 8'h56);
    push_pixel(12'd4095, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff);
    push_pixel(12'd320,  8'hc8, 8'h64, 8'h32, 8'h31, 8'h31, 8'h31);
    push_pixel(12'd320,  8'hc8, 8'h64, 8'h32, 8'h31, 8'h31, 8'h32);
    push_pixel(12'd320,  8'hc8, 8'h64, 8'h32, 8'h32, 8'h00, 8'h00);
    push_pixel(12'd1,    8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55);
    push_pixel(12'd321,  8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa);
    push_pixel(12'd160,  8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    push_pixel(12'd480,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_pixel(12'd2048, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20);
    add_random(200);
    wait_drained();

    // Start with a stray top bit, no pixel ever dark
    load_setting(13'h15ff, 13'd1600, 13'd0);
    add_random(250);
    wait_drained();

    // One-column overlap at the right edge, end clamped, every pixel dark-able
    load_setting(13'd4095, 13'd8191, 13'd255);
    add_random(250);
    wait_drained();

    // Roles swap: sender idles a lot, receiver a little
    send_idle_pct = 70;
    recv_idle_pct = 12;

    // Empty overlap, threshold with stray upper bits
    load_setting(13'd2000, 13'd2000, 13'h1ff);
    add_random(250);
    wait_drained();

    // Inverted overlap
    load_setting(13'd3000, 13'd1000, 13'd128);
    add_random(250);
    wait_drained();

    // Narrowest overlap at the left edge
    load_setting(13'd0, 13'd1, 13'd1);
    add_random(250);
    wait_drained();

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // Overlap over the whole row
    load_setting(13'd0, 13'd4096, 13'd50);
    add_random(250);
    wait_drained();

    load_setting(13'($urandom_range(0, 4095)), 13'($urandom_range(1, 8191)),
                 13'($urandom_range(0, 255)));
    add_random(250);
    wait_drained();

    load_setting(13'd10, 13'd30, 13'd200);
    add_random(250);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS seam_feather_blend");
    end else begin
      $display("FAIL seam_feather_blend");
    end
    $finish;
  end

endmodule

/* seam_feather_blend.f */
+incdir+rtl
rtl/sfb_pkg.sv
rtl/sfb_weight_pipe.sv
rtl/sfb_mix_lane.sv
rtl/seam_feather_blend.sv
rtl/sfb_checker.sv
sim/seam_feather_blend_tb.sv
